[rtl/core/rsu_pkg.sv]
// ----------------------------------------------------------------------------
// rsu_pkg
// Shared types, character codes and helper functions for the resource string
// unescaper.
// ----------------------------------------------------------------------------
package rsu_pkg;

   localparam int UnitWidth   = 16;
   localparam int StatusWidth = 2;
   localparam int HexCntWidth = 3;
   localparam int HexDigits   = 4;
   localparam int HexAlphaBase = 10;

   // result buffer
   localparam int BufDepth    = 4;
   localparam int BufPtrWidth = $clog2(BufDepth);
   localparam int BufCntWidth = $clog2(BufDepth + 1);

   localparam logic [StatusWidth-1:0] StatusChar       = 2'd0;
   localparam logic [StatusWidth-1:0] StatusApostrophe = 2'd1;
   localparam logic [StatusWidth-1:0] StatusBadEscape  = 2'd2;

   localparam logic [UnitWidth-1:0] CharNull       = 16'h0000;
   localparam logic [UnitWidth-1:0] CharTab        = 16'h0009;
   localparam logic [UnitWidth-1:0] CharNewline    = 16'h000A;
   localparam logic [UnitWidth-1:0] CharCr         = 16'h000D;
   localparam logic [UnitWidth-1:0] CharSpace      = 16'h0020;
   localparam logic [UnitWidth-1:0] CharQuote      = 16'h0022;
   localparam logic [UnitWidth-1:0] CharHash       = 16'h0023;
   localparam logic [UnitWidth-1:0] CharApostrophe = 16'h0027;
   localparam logic [UnitWidth-1:0] CharDigit0     = 16'h0030;
   localparam logic [UnitWidth-1:0] CharDigit9     = 16'h0039;
   localparam logic [UnitWidth-1:0] CharQuestion   = 16'h003F;
   localparam logic [UnitWidth-1:0] CharAt         = 16'h0040;
   localparam logic [UnitWidth-1:0] CharUpperA     = 16'h0041;
   localparam logic [UnitWidth-1:0] CharUpperF     = 16'h0046;
   localparam logic [UnitWidth-1:0] CharBackslash  = 16'h005C;
   localparam logic [UnitWidth-1:0] CharLowerA     = 16'h0061;
   localparam logic [UnitWidth-1:0] CharLowerF     = 16'h0066;
   localparam logic [UnitWidth-1:0] CharLowerN     = 16'h006E;
   localparam logic [UnitWidth-1:0] CharLowerT     = 16'h0074;
   localparam logic [UnitWidth-1:0] CharLowerU     = 16'h0075;

   typedef struct packed {
      logic [UnitWidth-1:0]   unit;
      logic [StatusWidth-1:0] status;
      logic                   last;
   } result_type;

   function automatic logic is_ws(input logic [UnitWidth-1:0] c);
      logic ws;
      ws = (c == CharSpace) || (c inside {[CharTab:CharCr]});
      return ws;
   endfunction

   // {valid, nibble}
   function automatic logic [4:0] hex_value(input logic [UnitWidth-1:0] c);
      logic [4:0] hv;
      logic [UnitWidth-1:0] diff;
      hv = 5'd0;
      diff = '0;
      if (c inside {[CharDigit0:CharDigit9]}) begin
         diff = c - CharDigit0;
         hv = {1'b1, diff[3:0]};
      end else if (c inside {[CharLowerA:CharLowerF]}) begin
         diff = c - CharLowerA + UnitWidth'(HexAlphaBase);
         hv = {1'b1, diff[3:0]};
      end else if (c inside {[CharUpperA:CharUpperF]}) begin
         diff = c - CharUpperA + UnitWidth'(HexAlphaBase);
         hv = {1'b1, diff[3:0]};
      end
      return hv;
   endfunction

endpackage

[rtl/core/resource_string_unescaper_top.sv]
// ----------------------------------------------------------------------------
// resource_string_unescaper_top
// Unescapes a stream of UTF-16 code units: whitespace collapse, quoting,
// backslash and \u escapes, sticky error reporting.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                          tlast
//  req      in   [15:0] code_unit               string_end
//  rsp      out  [15:0] out_unit, [17:16] status last_of_run
//
//  One code unit is taken per cycle while req_tready is high; each word's
//  results are worked out in the accepting cycle and land in a four-deep
//  result buffer. req_tready is high while the buffer has room for two
//  results, so a unit that yields one result sustains one word per cycle;
//  an inserted space adds one more output word.
//  Synchronous reset clears all scan state and empties the buffer.
//  A stall on rsp backs up into req once three results are waiting.
// ----------------------------------------------------------------------------
module resource_string_unescaper_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] code_unit
   input  logic        req_tlast,   // string_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] out_unit, [17:16] status, zero fill
   output logic        rsp_tlast    // last_of_run
);

   // scan state
   logic                             in_quote_ff, in_quote_in;
   logic                             pending_space_ff, pending_space_in;
   logic                             escape_pending_ff, escape_pending_in;
   logic                             hex_active_ff, hex_active_in;
   logic [rsu_pkg::HexCntWidth-1:0]  hex_count_ff, hex_count_in;
   logic [rsu_pkg::UnitWidth-1:0]    hex_accum_ff, hex_accum_in;
   logic                             error_seen_ff, error_seen_in;
   logic                             output_nonempty_ff, output_nonempty_in;

   // result buffer
   rsu_pkg::result_type              buf_ff [rsu_pkg::BufDepth];
   logic [rsu_pkg::BufPtrWidth-1:0]  head_ff, head_in;
   logic [rsu_pkg::BufPtrWidth-1:0]  tail_ff, tail_in;
   logic [rsu_pkg::BufCntWidth-1:0]  count_ff, count_in;

   logic                             accept;
   logic                             pop;
   logic [rsu_pkg::UnitWidth-1:0]    c;
   logic                             last;
   logic [4:0]                       hv;
   logic [rsu_pkg::UnitWidth-1:0]    accum_next;
   logic [rsu_pkg::HexCntWidth-1:0]  count_next;

   logic                             flush_emit;   // collapsed space goes out
   logic                             main_emit;
   logic [rsu_pkg::UnitWidth-1:0]    main_unit;
   logic [rsu_pkg::StatusWidth-1:0]  main_status;
   logic                             flush_req;

   rsu_pkg::result_type              res_first, res_second;
   logic [1:0]                       push_cnt;
   logic [rsu_pkg::BufPtrWidth-1:0]  tail_plus1;

   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = (count_ff <= rsu_pkg::BufCntWidth'(rsu_pkg::BufDepth - 2));
   assign c          = req_tdata;
   assign last       = req_tlast;
   assign hv         = rsu_pkg::hex_value(c);
   assign accum_next = {hex_accum_ff[rsu_pkg::UnitWidth-5:0], hv[3:0]};
   assign count_next = hex_count_ff + rsu_pkg::HexCntWidth'(1);

   always_comb begin
      in_quote_in        = in_quote_ff;
      pending_space_in   = pending_space_ff;
      escape_pending_in  = escape_pending_ff;
      hex_active_in      = hex_active_ff;
      hex_count_in       = hex_count_ff;
      hex_accum_in       = hex_accum_ff;
      flush_req          = 1'b0;
      main_emit          = 1'b0;
      main_unit          = rsu_pkg::CharNull;
      main_status        = rsu_pkg::StatusChar;

      if (error_seen_ff) begin
         // sticky: nothing more until reset
      end else if (hex_active_ff) begin
         if (!hv[4]) begin
            hex_active_in = 1'b0;
            hex_count_in  = '0;
            main_emit     = 1'b1;
            main_status   = rsu_pkg::StatusBadEscape;
         end else begin
            hex_accum_in = accum_next;
            hex_count_in = count_next;
            if (count_next >= rsu_pkg::HexCntWidth'(rsu_pkg::HexDigits) || last) begin
               main_emit     = 1'b1;
               main_unit     = accum_next;
               hex_active_in = 1'b0;
               hex_count_in  = '0;
               hex_accum_in  = '0;
            end
         end
      end else if (escape_pending_ff) begin
         escape_pending_in = 1'b0;
         case (c)
            rsu_pkg::CharLowerT: begin
               main_emit = 1'b1;
               main_unit = rsu_pkg::CharTab;
            end
            rsu_pkg::CharLowerN: begin
               main_emit = 1'b1;
               main_unit = rsu_pkg::CharNewline;
            end
            rsu_pkg::CharHash, rsu_pkg::CharAt, rsu_pkg::CharQuestion,
            rsu_pkg::CharQuote, rsu_pkg::CharApostrophe, rsu_pkg::CharBackslash: begin
               main_emit = 1'b1;
               main_unit = c;
            end
            rsu_pkg::CharLowerU: begin
               if (last) begin
                  main_emit = 1'b1;
               end else begin
                  hex_active_in = 1'b1;
                  hex_count_in  = '0;
                  hex_accum_in  = '0;
               end
            end
            default: begin
               // unknown escape: dropped
            end
         endcase
      end else if (c == rsu_pkg::CharQuote) begin
         flush_req   = !in_quote_ff && pending_space_ff;
         in_quote_in = !in_quote_ff;
      end else if (c == rsu_pkg::CharApostrophe && !in_quote_ff) begin
         main_emit   = 1'b1;
         main_status = rsu_pkg::StatusApostrophe;
      end else if (c == rsu_pkg::CharBackslash) begin
         flush_req         = !in_quote_ff && pending_space_ff;
         escape_pending_in = !last;
      end else if (!in_quote_ff) begin
         if (rsu_pkg::is_ws(c)) begin
            pending_space_in = 1'b1;
         end else begin
            flush_req = pending_space_ff;
            main_emit = 1'b1;
            main_unit = c;
         end
      end else begin
         main_emit = 1'b1;
         main_unit = c;
      end

      if (flush_req) begin
         pending_space_in = 1'b0;
      end
   end

   assign flush_emit = flush_req && output_nonempty_ff;

   always_comb begin
      output_nonempty_in = output_nonempty_ff;
      error_seen_in      = error_seen_ff;
      if (accept) begin
         if (flush_emit || (main_emit && main_status == rsu_pkg::StatusChar)) begin
            output_nonempty_in = 1'b1;
         end
         if (main_emit && main_status != rsu_pkg::StatusChar) begin
            error_seen_in = 1'b1;
         end
      end
   end

   always_comb begin
      res_first  = '{unit: rsu_pkg::CharSpace, status: rsu_pkg::StatusChar, last: 1'b0};
      res_second = '{unit: main_unit, status: main_status, last: 1'b1};
      push_cnt   = 2'd0;
      if (accept) begin
         if (flush_emit && main_emit) begin
            push_cnt = 2'd2;
         end else if (flush_emit) begin
            res_first.last = 1'b1;
            push_cnt       = 2'd1;
         end else if (main_emit) begin
            res_first = res_second;
            push_cnt  = 2'd1;
         end
      end
   end

   assign tail_plus1 = tail_ff + rsu_pkg::BufPtrWidth'(1);
   assign tail_in    = tail_ff + rsu_pkg::BufPtrWidth'(push_cnt);
   assign head_in    = head_ff + rsu_pkg::BufPtrWidth'(pop);
   assign count_in   = count_ff + rsu_pkg::BufCntWidth'(push_cnt)
                       - rsu_pkg::BufCntWidth'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quote_ff        <= 1'b0;
         pending_space_ff   <= 1'b0;
         escape_pending_ff  <= 1'b0;
         hex_active_ff      <= 1'b0;
         hex_count_ff       <= '0;
         hex_accum_ff       <= '0;
         error_seen_ff      <= 1'b0;
         output_nonempty_ff <= 1'b0;
         head_ff            <= '0;
         tail_ff            <= '0;
         count_ff           <= '0;
      end else begin
         if (accept) begin
            in_quote_ff       <= in_quote_in;
            pending_space_ff  <= pending_space_in;
            escape_pending_ff <= escape_pending_in;
            hex_active_ff     <= hex_active_in;
            hex_count_ff      <= hex_count_in;
            hex_accum_ff      <= hex_accum_in;
         end
         error_seen_ff      <= error_seen_in;
         output_nonempty_ff <= output_nonempty_in;
         head_ff            <= head_in;
         tail_ff            <= tail_in;
         count_ff           <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         buf_ff[tail_ff] <= res_first;
      end
      if (push_cnt == 2'd2) begin
         buf_ff[tail_plus1] <= res_second;
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {6'd0, buf_ff[head_ff].status, buf_ff[head_ff].unit};
   assign rsp_tlast  = buf_ff[head_ff].last;

   // buffer never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rsu_pkg::BufCntWidth'(rsu_pkg::BufDepth))
      else $error("result buffer overflow");

   // once an error is out, no further result is produced
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      error_seen_ff |-> push_cnt == 2'd0)
      else $error("result pushed after error");

   // an error result is always alone and last
   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      (main_emit && accept && main_status != rsu_pkg::StatusChar) |-> push_cnt == 2'd1)
      else $error("error result paired with another result");

   // a two-result push is inserted space followed by a character
   a_pair_shape: assert property (@(posedge clock) disable iff (reset)
      push_cnt == 2'd2 |-> (res_first.unit == rsu_pkg::CharSpace && !res_first.last
                            && res_second.status == rsu_pkg::StatusChar))
      else $error("malformed result pair");

   // escape and hex collection never run together
   a_escape_excl: assert property (@(posedge clock) disable iff (reset)
      !(escape_pending_ff && hex_active_ff))
      else $error("escape and hex active together");

endmodule

[dv/rsu_checker.sv]
// ----------------------------------------------------------------------------
// rsu_checker
// Watches both stream channels of the unescaper, predicts the output words
// for every accepted code unit and compares them in order with what the
// block sends.
// ----------------------------------------------------------------------------
module rsu_checker
   import rsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] code_unit
   input  logic        req_tlast,   // string_end
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [15:0] out_unit, [17:16] status, zero fill
   input  logic        rsp_tlast,   // last_of_run
   output int          fault_count,
   output int          owed_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // scan state of the predictor
   logic                 quoted;
   logic                 space_owed;
   logic                 after_backslash;
   logic                 in_hex;
   logic [HexCntWidth-1:0] hex_len;
   logic [UnitWidth-1:0] hex_acc;
   logic                 halted;
   logic                 emitted_any;

   result_type           unit_words[2];
   int                   n_words;
   result_type           owed_words[$];
   result_type           want;
   int                   faults = 0;

   function automatic void emit(input logic [UnitWidth-1:0] u,
                                input logic [StatusWidth-1:0] s);
      if (n_words < 2) begin
         unit_words[n_words] = {u, s, 1'b0};
         n_words++;
         if (s == StatusChar) emitted_any = 1'b1;
         else halted = 1'b1;
      end
   endfunction

   function automatic void settle_space();
      if (emitted_any) emit(CharSpace, StatusChar);
      space_owed = 1'b0;
   endfunction

   function automatic void unescape_unit(input logic [UnitWidth-1:0] c,
                                         input logic at_end);
      logic [4:0] nib;   // {valid, value}
      nib = 5'd0;
      n_words = 0;
      if (halted) return;
      if (c >= CharDigit0 && c <= CharDigit9) nib = {1'b1, 4'(c - CharDigit0)};
      else if (c >= CharLowerA && c <= CharLowerF) nib = {1'b1, 4'(c - CharLowerA + 10)};
      else if (c >= CharUpperA && c <= CharUpperF) nib = {1'b1, 4'(c - CharUpperA + 10)};

      if (in_hex) begin
         if (!nib[4]) begin
            in_hex  = 1'b0;
            hex_len = '0;
            emit(CharNull, StatusBadEscape);
         end else begin
            hex_acc = {hex_acc[11:0], nib[3:0]};
            hex_len = hex_len + 1'b1;
            if (hex_len >= HexDigits || at_end) begin
               emit(hex_acc, StatusChar);
               in_hex  = 1'b0;
               hex_len = '0;
               hex_acc = '0;
            end
         end
      end else if (after_backslash) begin
         after_backslash = 1'b0;
         case (c)
            CharLowerT: emit(CharTab, StatusChar);
            CharLowerN: emit(CharNewline, StatusChar);
            CharHash, CharAt, CharQuestion, CharQuote, CharApostrophe,
            CharBackslash: emit(c, StatusChar);
            CharLowerU: begin
               if (at_end) begin
                  emit(CharNull, StatusChar);
               end else begin
                  in_hex  = 1'b1;
                  hex_len = '0;
                  hex_acc = '0;
               end
            end
            default: ;
         endcase
      end else if (c == CharQuote) begin
         if (!quoted && space_owed) settle_space();
         quoted = !quoted;
      end else if (c == CharApostrophe && !quoted) begin
         emit(CharNull, StatusApostrophe);
      end else if (c == CharBackslash) begin
         if (!quoted && space_owed) settle_space();
         if (!at_end) after_backslash = 1'b1;
      end else if (!quoted) begin
         if (c == CharSpace || (c >= CharTab && c <= CharCr)) begin
            space_owed = 1'b1;
         end else begin
            if (space_owed) settle_space();
            emit(c, StatusChar);
         end
      end else begin
         emit(c, StatusChar);
      end

      if (n_words > 0) unit_words[n_words-1].last = 1'b1;
      for (int i = 0; i < n_words; i++) owed_words.push_back(unit_words[i]);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         quoted          = 1'b0;
         space_owed      = 1'b0;
         after_backslash = 1'b0;
         in_hex          = 1'b0;
         hex_len         = '0;
         hex_acc         = '0;
         halted          = 1'b0;
         emitted_any     = 1'b0;
         owed_words.delete();
      end else begin
         if (req_tvalid && req_tready) unescape_unit(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (owed_words.size() == 0) begin
               $display("%0t: unexpected word: expected none, got unit %h status %0d last %0d",
                        $time, rsp_tdata[15:0], rsp_tdata[17:16], rsp_tlast);
               faults++;
            end else begin
               want = owed_words.pop_front();
               if (rsp_tdata[15:0] != want.unit) begin
                  $display("%0t: out_unit mismatch: expected %h, got %h",
                           $time, want.unit, rsp_tdata[15:0]);
                  faults++;
               end
               if (rsp_tdata[17:16] != want.status) begin
                  $display("%0t: status mismatch: expected %0d, got %0d",
                           $time, want.status, rsp_tdata[17:16]);
                  faults++;
               end
               if (rsp_tlast != want.last) begin
                  $display("%0t: last_of_run mismatch: expected %0d, got %0d",
                           $time, want.last, rsp_tlast);
                  faults++;
               end
            end
         end
      end
      fault_count <= faults;
      owed_count  <= owed_words.size();
   end

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives the resource string unescaper with directed strings, then random
// well-formed strings under changing backpressure, and ends with one sticky
// error followed by ignored noise. Checking is done in rsu_checker.
// ----------------------------------------------------------------------------
module tb;
   import rsu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomUnits = 500;
   localparam int QuietLimit  = 3000;
   localparam int DrainCycles = 20;
   localparam logic [UnitWidth-1:0] CharLowerQ = 16'h0071;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [15:0] code_unit
   logic        req_tlast = 1'b0; // string_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [15:0] out_unit, [17:16] status, zero fill
   logic        rsp_tlast;        // last_of_run

   int fault_count;
   int owed_count;
   int idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   resource_string_unescaper_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   rsu_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .fault_count (fault_count),
      .owed_count  (owed_count)
   );

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic send_unit(input logic [15:0] u, input logic at_end);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= u;
      req_tlast  <= at_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [15:0] hex_char(input logic [3:0] v);
      if (v < 10) return CharDigit0 + v;
      if ($urandom_range(1)) return CharUpperA + v - 10;
      return CharLowerA + v - 10;
   endfunction

   // anything that is taken literally in the current quote state
   function automatic logic [15:0] plain_unit(input logic quoted);
      logic [15:0] u;
      do begin
         if ($urandom_range(1)) u = 16'($urandom_range(16'h21, 16'h7E));
         else u = 16'($urandom);
      end while (u == CharQuote || u == CharBackslash ||
                 (u == CharApostrophe && !quoted));
      return u;
   endfunction

   initial begin
      logic [15:0] line_units[$];
      logic        gen_quoted;
      logic [15:0] u;
      int          units_sent;
      int          pick;

      gen_quoted = 1'b0;
      units_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed strings
      send_unit(CharSpace, 1'b0);        // leading space, nothing emitted yet
      send_unit(16'hFFFF, 1'b0);
      send_unit(CharNull, 1'b0);
      send_unit(CharCr, 1'b0);
      send_unit(CharQuote, 1'b0);        // owed space goes out here
      send_unit(CharApostrophe, 1'b0);
      send_unit(CharSpace, 1'b0);
      send_unit(CharQuote, 1'b1);
      send_unit(CharTab, 1'b0);
      send_unit(CharBackslash, 1'b0);    // owed space goes out here
      send_unit(CharLowerT, 1'b0);
      send_unit(CharBackslash, 1'b0);
      send_unit(CharLowerN, 1'b0);
      send_unit(CharBackslash, 1'b0);
      send_unit(CharLowerU, 1'b0);
      send_unit(CharUpperA, 1'b0);
      send_unit(CharLowerF, 1'b0);
      send_unit(CharDigit0, 1'b0);
      send_unit(CharDigit9, 1'b0);
      send_unit(CharBackslash, 1'b0);    // \u cut short by string end
      send_unit(CharLowerU, 1'b0);
      send_unit(CharUpperF, 1'b0);
      send_unit(CharLowerA, 1'b1);
      send_unit(CharBackslash, 1'b0);
      send_unit(CharLowerU, 1'b1);
      send_unit(CharBackslash, 1'b1);
      send_unit(CharBackslash, 1'b0);
      send_unit(CharLowerQ, 1'b0);
      send_unit(CharNewline, 1'b0);
      send_unit(CharLowerN, 1'b1);

      // random well-formed strings, backpressure mode rotates every 64 code units sent
      while (units_sent < RandomUnits) begin
         case ((units_sent / 64) % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 86; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 86; end
            default: begin idle_pct = 32; stall_pct = 32; end
         endcase
         line_units.delete();
         repeat ($urandom_range(1, 8)) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
               line_units.push_back(plain_unit(gen_quoted));
            end else if (pick < 55) begin
               repeat ($urandom_range(1, 3)) begin
                  u = 16'($urandom_range(9, 14));
                  line_units.push_back(u == 14 ? CharSpace : u);
               end
            end else if (pick < 67) begin
               line_units.push_back(CharQuote);
               gen_quoted = !gen_quoted;
            end else if (pick < 75) begin
               line_units.push_back(gen_quoted ? CharApostrophe : plain_unit(1'b0));
            end else if (pick < 90) begin
               line_units.push_back(CharBackslash);
               case ($urandom_range(8))
                  0: u = CharLowerT;
                  1: u = CharLowerN;
                  2: u = CharHash;
                  3: u = CharAt;
                  4: u = CharQuestion;
                  5: u = CharQuote;
                  6: u = CharApostrophe;
                  7: u = CharBackslash;
                  default: do u = 16'($urandom); while (u == CharLowerU);
               endcase
               line_units.push_back(u);
            end else begin
               line_units.push_back(CharBackslash);
               line_units.push_back(CharLowerU);
               repeat (HexDigits) line_units.push_back(hex_char(4'($urandom)));
            end
         end
         // endings that only make sense at string end
         pick = $urandom_range(99);
         if (pick < 12) begin
            line_units.push_back(CharBackslash);
         end else if (pick < 25) begin
            line_units.push_back(CharBackslash);
            line_units.push_back(CharLowerU);
            repeat ($urandom_range(0, 3)) line_units.push_back(hex_char(4'($urandom)));
         end
         foreach (line_units[i]) send_unit(line_units[i], i == line_units.size() - 1);
         units_sent += line_units.size();
      end

      // one sticky error, then noise that must produce nothing
      if ($urandom_range(1)) begin
         if (gen_quoted) send_unit(CharQuote, 1'b0);
         send_unit(CharSpace, 1'b0);
         send_unit(CharApostrophe, 1'b0);
      end else begin
         send_unit(CharBackslash, 1'b0);
         send_unit(CharLowerU, 1'b0);
         repeat ($urandom_range(0, 3)) send_unit(hex_char(4'($urandom)), 1'b0);
         do begin
            if ($urandom_range(1)) u = 16'($urandom_range(16'h20, 16'h7E));
            else u = 16'($urandom);
         end while (u inside {[CharDigit0:CharDigit9], [CharLowerA:CharLowerF],
                              [CharUpperA:CharUpperF]});
         send_unit(u, 1'b0);
      end
      repeat (15) send_unit(16'($urandom), 1'($urandom_range(1)));
      send_unit(16'($urandom), 1'b1);
      req_tvalid <= 1'b0;

      while (owed_count != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (fault_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/rsu_pkg.sv
rtl/core/resource_string_unescaper_top.sv
dv/rsu_checker.sv
dv/tb.sv
